>>> rtl/etq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etq_pkg
// Shared types, constants and helpers of the event timing queue.
// ----------------------------------------------------------------------------
package etq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int KIND_BITS_DEF   = 8;
    localparam int MAX_RESULTS     = 32;
    localparam int FB_W            = $clog2(MAX_RESULTS);
    localparam int N_W             = $clog2(MAX_RESULTS + 1);
    localparam int SCALED_W        = 39;
    localparam int PCT_W           = 9;
    localparam int CFG_W           = 31;
    localparam int CFG_ADDR_W      = 2;
    localparam int SAT_W           = 41;
    localparam int CMD_FIFO_DEPTH  = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_CLOCK_PERCENT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUEUE_LOCKED  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_SLICE = 2'd2;

    localparam logic [PCT_W-1:0] PCT_RESET   = 9'd100;
    localparam logic [30:0]      SLICE_RESET = 31'd20000;
    localparam logic [30:0]      MASK31      = 31'h7fff_ffff;

    typedef enum logic [2:0] {
        REQ_SCHEDULE  = 3'd0,
        REQ_REMOVE_KU = 3'd1,
        REQ_REMOVE_K  = 3'd2,
        REQ_ADD_TICKS = 3'd3,
        REQ_ADVANCE   = 3'd4,
        REQ_SET_SLICE = 3'd5,
        REQ_IDLE      = 3'd6,
        REQ_STATUS    = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_LOCKED = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] delay_cycles;
        logic [7:0]         event_kind;
        logic [63:0]        user_word;
        logic [31:0]        tick_amount;
        logic [30:0]        slice_limit;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic               fired;
        logic [7:0]         fired_kind;
        logic [63:0]        fired_user;
        logic [30:0]        late_cycles;
        logic               last;
        logic [62:0]        now_ticks;
        logic signed [31:0] downcount_now;
        logic [31:0]        idle_total;
        logic [30:0]        slice_room;
    } t_out_beat;

    typedef struct packed {
        t_req               op;
        logic signed [31:0] delay_cycles;
        logic [7:0]         event_kind;
        logic [63:0]        user_word;
        logic [SCALED_W-1:0] scaled;
        logic [30:0]        slice_limit;
    } t_cmd;

    typedef struct packed {
        logic [PCT_W-1:0] clock_percent;
        logic             queue_locked;
        logic [30:0]      default_slice;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v[SAT_W-1:31] != {(SAT_W-31){v[SAT_W-1]}}) begin
            r = v[SAT_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/etq_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etq_div
// Restoring divider, one quotient bit per cycle, for scaled tick counts.
// ----------------------------------------------------------------------------
module etq_div import etq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SCALED_W-1:0] i_dividend,
    input  logic [PCT_W-1:0]    i_divisor,
    output logic                o_done,
    output logic [SCALED_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(SCALED_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PCT_W-1:0]    r_rem;
    logic [PCT_W-1:0]    r_div;
    logic [SCALED_W-1:0] r_quo;
    logic [PCT_W:0]      rem_sh;
    logic [PCT_W:0]      rem_sub;
    logic                fits;

    assign rem_sh  = {r_rem, r_quo[SCALED_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign fits    = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SCALED_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= (i_divisor == '0) ? PCT_W'(1) : i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= rem_sub[PCT_W-1:0];
            end else begin
                r_rem <= rem_sh[PCT_W-1:0];
            end
            r_quo <= {r_quo[SCALED_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

>>> rtl/etq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etq_front
// Accepts request beats, decodes them and scales add-ticks amounts.
// ----------------------------------------------------------------------------
module etq_front import etq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_data,
    input  logic [PCT_W-1:0] i_clock_percent,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output t_cmd             o_cmd
);
    logic                r_pend;
    logic                r_divd;
    t_cmd                r_cmd;
    t_cmd                in_cmd;
    t_cmd                div_cmd;
    logic                is_add;
    logic                accept;
    logic                div_done;
    logic [SCALED_W-1:0] tk;
    logic [SCALED_W-1:0] dividend;
    logic [SCALED_W-1:0] quotient;

    always_comb begin
        in_cmd.op           = t_req'(i_in_data.req_type);
        in_cmd.delay_cycles = i_in_data.delay_cycles;
        in_cmd.event_kind   = i_in_data.event_kind;
        in_cmd.user_word    = i_in_data.user_word;
        in_cmd.scaled       = '0;
        in_cmd.slice_limit  = i_in_data.slice_limit;
    end

    // ticks times one hundred
    assign tk       = SCALED_W'(i_in_data.tick_amount);
    assign dividend = (tk << 6) + (tk << 5) + (tk << 2);

    assign is_add     = in_cmd.op == REQ_ADD_TICKS;
    assign o_in_ready = !r_pend && i_cmd_ready;
    assign accept     = i_in_valid && o_in_ready;

    etq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && is_add),
        .i_dividend (dividend),
        .i_divisor  (i_clock_percent),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        div_cmd        = r_cmd;
        div_cmd.scaled = quotient;
    end

    assign o_cmd_valid = r_divd || (accept && !is_add);
    assign o_cmd       = r_divd ? div_cmd : in_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_divd <= 1'b0;
        end else begin
            if (accept && is_add) begin
                r_pend <= 1'b1;
            end
            if (div_done) begin
                r_divd <= 1'b1;
            end
            if (r_divd && i_cmd_ready) begin
                r_divd <= 1'b0;
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_add) begin
            r_cmd <= in_cmd;
        end
    end
endmodule
`default_nettype wire

>>> rtl/etq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etq_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module etq_fifo import etq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);
    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    t_cmd             r_mem [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_cnt != CNT_W'(CMD_FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

>>> rtl/etq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etq_back
// Event store, scan engine, slice bookkeeping and result output register.
// ----------------------------------------------------------------------------
module etq_back import etq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KIND_BITS   = KIND_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    output logic      o_cmd_pop,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_FETCH  = 7'b0001000,
        S_TAKE   = 7'b0010000,
        S_ERD    = 7'b0100000,
        S_EOUT   = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        M_FINAL  = 2'd0,
        M_ALLOC  = 2'd1,
        M_REMOVE = 2'd2,
        M_FIRE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0]  kind;
        logic [63:0] user;
        logic [30:0] late;
    } t_fire;

    t_state r_state;
    t_mode  r_mode;
    t_cmd   r_cmd;
    t_status r_status;

    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [31:0]            r_order;
    logic [63:0]            r_exec;
    logic signed [31:0]     r_slice;
    logic signed [31:0]     r_down;
    logic [31:0]            r_idle;
    logic [30:0]            r_room;
    logic [N_W-1:0]         r_n;
    logic [N_W-1:0]         r_k;

    logic [IDX_W-1:0] r_sidx;
    logic             r_issued;
    logic             r_dvld;
    logic [IDX_W-1:0] r_didx;
    logic             r_bfound;
    logic [63:0]      r_btime;
    logic [31:0]      r_border;
    logic [IDX_W-1:0] r_bidx;
    logic             r_ffound;
    logic [IDX_W-1:0] r_fidx;

    logic [63:0]          m_time  [QUEUE_DEPTH];
    logic [31:0]          m_order [QUEUE_DEPTH];
    logic [KIND_BITS-1:0] m_kind  [QUEUE_DEPTH];
    logic [63:0]          m_user  [QUEUE_DEPTH];
    logic [63:0]          r_rd_time;
    logic [31:0]          r_rd_order;
    logic [KIND_BITS-1:0] r_rd_kind;
    logic [63:0]          r_rd_user;

    t_fire m_fb [MAX_RESULTS];
    t_fire r_fb_q;

    logic      r_out_valid;
    t_out_beat r_out;

    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [63:0]          new_time;
    logic [KIND_BITS-1:0] cmd_kind;
    logic                 cur_valid;
    logic                 rm_hit;
    logic                 take_best;
    logic                 scan_end;
    logic [63:0]          ahead;
    logic [63:0]          late;
    logic                 due;
    logic [30:0]          room;
    logic [30:0]          late31;
    logic signed [31:0]   set_s;
    logic signed [31:0]   clamp_c;
    logic signed [33:0]   shorten;
    logic signed [SAT_W-1:0] add_v;
    logic signed [33:0]   idle_v;
    logic [31:0]          idle_n;
    logic                 locked_op;
    logic                 out_free;
    logic                 is_last;
    logic [63:0]          now_full;

    assign rd_addr  = (r_state == S_FETCH) ? r_bidx : r_sidx;
    assign cmd_kind = KIND_BITS'(r_cmd.event_kind);
    assign mem_we   = (r_state == S_DECIDE) && (r_mode == M_ALLOC) && r_ffound;
    assign now_full = r_exec + {{32{r_slice[31]}}, r_slice} - {{32{r_down[31]}}, r_down};
    assign new_time = now_full + {{32{r_cmd.delay_cycles[31]}}, r_cmd.delay_cycles};

    // scan compare
    assign cur_valid = r_valid[r_didx];
    assign rm_hit    = (r_mode == M_REMOVE) && cur_valid && (r_rd_kind == cmd_kind)
                    && ((r_cmd.op == REQ_REMOVE_K) || (r_rd_user == r_cmd.user_word));
    assign take_best = cur_valid && !rm_hit
                    && (!r_bfound || ($signed(r_rd_time) < $signed(r_btime))
                        || ((r_rd_time == r_btime) && (r_rd_order < r_border)));
    assign scan_end  = r_dvld && (r_didx == IDX_W'(QUEUE_DEPTH - 1));

    // earliest entry against executed ticks
    assign ahead  = r_btime - r_exec;
    assign late   = r_exec - r_btime;
    assign due    = r_bfound && ($signed(r_btime) <= $signed(r_exec));
    assign late31 = (late[63:31] != '0) ? MASK31 : late[30:0];

    always_comb begin
        if (!r_bfound) begin
            room = i_cfg.default_slice;
        end else if (due) begin
            room = '0;
        end else if (ahead[63:31] != '0) begin
            room = MASK31;
        end else begin
            room = ahead[30:0];
        end
    end

    always_comb begin
        if (!r_bfound) begin
            set_s = {1'b0, r_cmd.slice_limit};
        end else if (due) begin
            if ((late[63:32] != '0) || (late[31] && (late[30:0] != '0))) begin
                set_s = 32'sh8000_0000;
            end else begin
                set_s = (~late[31:0]) + 32'd1;
            end
        end else if (ahead < {33'd0, r_cmd.slice_limit}) begin
            set_s = ahead[31:0];
        end else begin
            set_s = {1'b0, r_cmd.slice_limit};
        end
    end

    assign clamp_c = r_cmd.delay_cycles[31] ? 32'sd0 : r_cmd.delay_cycles;
    assign shorten = {{2{r_slice[31]}}, r_slice} - {{2{r_down[31]}}, r_down}
                   + {{2{clamp_c[31]}}, clamp_c};
    assign add_v   = {{(SAT_W-32){r_down[31]}}, r_down}
                   - {{(SAT_W-SCALED_W){1'b0}}, i_cmd.scaled};
    assign idle_v  = {2'b00, r_idle} + {{2{r_down[31]}}, r_down};

    always_comb begin
        if (idle_v[33]) begin
            idle_n = '0;
        end else if (idle_v[32]) begin
            idle_n = '1;
        end else begin
            idle_n = idle_v[31:0];
        end
    end

    assign locked_op = i_cfg.queue_locked && ((i_cmd.op == REQ_SCHEDULE)
                    || (i_cmd.op == REQ_REMOVE_KU) || (i_cmd.op == REQ_REMOVE_K));
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign out_free  = !r_out_valid || i_out_ready;
    assign is_last   = (r_n == '0) || (r_k == r_n - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_FINAL;
            r_valid     <= '0;
            r_order     <= '0;
            r_exec      <= '0;
            r_slice     <= '0;
            r_down      <= '0;
            r_idle      <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_sidx      <= '0;
            r_issued    <= 1'b0;
            r_dvld      <= 1'b0;
            r_bfound    <= 1'b0;
            r_ffound    <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_EOUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_n      <= '0;
                        r_status <= locked_op ? ST_LOCKED : ST_OK;
                        r_sidx   <= '0;
                        r_issued <= 1'b0;
                        r_dvld   <= 1'b0;
                        r_bfound <= 1'b0;
                        r_ffound <= 1'b0;
                        r_state  <= S_SCAN;
                        if (locked_op) begin
                            r_mode <= M_FINAL;
                        end else begin
                            case (i_cmd.op) inside
                                REQ_SCHEDULE: r_mode <= M_ALLOC;
                                REQ_REMOVE_KU, REQ_REMOVE_K: r_mode <= M_REMOVE;
                                REQ_ADD_TICKS: begin
                                    r_mode <= M_FINAL;
                                    r_down <= sat32(add_v);
                                end
                                REQ_ADVANCE: begin
                                    r_exec  <= now_full;
                                    r_idle  <= '0;
                                    r_slice <= '0;
                                    r_down  <= '0;
                                    r_mode  <= M_FIRE;
                                end
                                REQ_IDLE: begin
                                    r_mode <= M_FINAL;
                                    r_idle <= idle_n;
                                    r_down <= '0;
                                end
                                default: r_mode <= M_FINAL;
                            endcase
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_issued) begin
                        if (r_sidx == IDX_W'(QUEUE_DEPTH - 1)) begin
                            r_issued <= 1'b1;
                        end else begin
                            r_sidx <= r_sidx + 1'b1;
                        end
                    end
                    r_dvld <= !r_issued;
                    r_didx <= r_sidx;
                    if (r_dvld) begin
                        if (take_best) begin
                            r_bfound <= 1'b1;
                            r_bidx   <= r_didx;
                        end
                        if (!cur_valid && !r_ffound) begin
                            r_ffound <= 1'b1;
                            r_fidx   <= r_didx;
                        end
                        if (rm_hit) begin
                            r_valid[r_didx] <= 1'b0;
                        end
                    end
                    if (scan_end) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_room <= room;
                    r_k    <= '0;
                    if ((r_mode == M_ALLOC) && r_ffound) begin
                        r_valid[r_fidx] <= 1'b1;
                        r_order  <= r_order + 1'b1;
                        if (r_down > clamp_c) begin
                            r_slice <= sat32(SAT_W'(shorten));
                            r_down  <= clamp_c;
                        end
                        r_mode   <= M_FINAL;
                        r_sidx   <= '0;
                        r_issued <= 1'b0;
                        r_dvld   <= 1'b0;
                        r_bfound <= 1'b0;
                        r_ffound <= 1'b0;
                        r_state  <= S_SCAN;
                    end else if ((r_mode == M_FIRE) && due
                                 && (r_n < N_W'(MAX_RESULTS))) begin
                        r_state <= S_FETCH;
                    end else begin
                        if (r_mode == M_ALLOC) begin
                            r_status <= ST_FULL;
                        end
                        if ((r_mode == M_FINAL) && (r_cmd.op == REQ_SET_SLICE)) begin
                            r_slice <= set_s;
                            r_down  <= set_s;
                        end
                        r_state <= (r_n == '0) ? S_EOUT : S_ERD;
                    end
                end
                S_FETCH: begin
                    r_state <= S_TAKE;
                end
                S_TAKE: begin
                    r_valid[r_bidx] <= 1'b0;
                    r_n      <= r_n + 1'b1;
                    r_sidx   <= '0;
                    r_issued <= 1'b0;
                    r_dvld   <= 1'b0;
                    r_bfound <= 1'b0;
                    r_ffound <= 1'b0;
                    r_state  <= S_SCAN;
                end
                S_ERD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request latch, best entry payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if ((r_state == S_SCAN) && r_dvld && take_best) begin
            r_btime  <= r_rd_time;
            r_border <= r_rd_order;
        end
    end

    // event store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_time[r_fidx]  <= new_time;
            m_order[r_fidx] <= r_order;
            m_kind[r_fidx]  <= cmd_kind;
            m_user[r_fidx]  <= r_cmd.user_word;
        end
        r_rd_time  <= m_time[rd_addr];
        r_rd_order <= m_order[rd_addr];
        r_rd_kind  <= m_kind[rd_addr];
        r_rd_user  <= m_user[rd_addr];
    end

    // fired event buffer
    always_ff @(posedge i_clk) begin
        if (r_state == S_TAKE) begin
            m_fb[r_n[FB_W-1:0]] <= '{kind: 8'(r_rd_kind), user: r_rd_user, late: late31};
        end
        if (r_state == S_ERD) begin
            r_fb_q <= m_fb[r_k[FB_W-1:0]];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EOUT) && out_free) begin
            r_out.status        <= r_status;
            r_out.fired         <= r_n != '0;
            r_out.fired_kind    <= (r_n != '0) ? r_fb_q.kind : '0;
            r_out.fired_user    <= (r_n != '0) ? r_fb_q.user : '0;
            r_out.late_cycles   <= (r_n != '0) ? r_fb_q.late : '0;
            r_out.last          <= is_last;
            r_out.now_ticks     <= now_full[62:0];
            r_out.downcount_now <= r_down;
            r_out.idle_total    <= r_idle;
            r_out.slice_room    <= r_room;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

>>> rtl/event_timing_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// event_timing_queue_unit
// Time-ordered event queue for one emulated core with slice bookkeeping.
// ----------------------------------------------------------------------------
// Requests enter a front stage that decodes them. An add-ticks request is held
// there while a bit-serial divider forms ticks*100/clock_percent (39 quotient
// bits); it reaches the command queue once the quotient is done, and the input
// is not ready meanwhile. The back engine walks the event store one entry per
// cycle for each request; a schedule that finds a free slot scans again, an
// advance scans again for each fired event, and each result beat of a fired
// event is read through the fired-event buffer. Stalls on the result side hold
// the back engine. The event store needs no clearing pass after reset; results
// leave through a registered output beat.
module event_timing_queue_unit import etq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KIND_BITS   = KIND_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);
    t_cfg r_cfg;
    logic f_valid;
    t_cmd f_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_percent <= PCT_RESET;
            r_cfg.queue_locked  <= 1'b0;
            r_cfg.default_slice <= SLICE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CLOCK_PERCENT: r_cfg.clock_percent <= i_cfg_wdata[PCT_W-1:0];
                CFG_QUEUE_LOCKED:  r_cfg.queue_locked  <= i_cfg_wdata[0];
                CFG_DEFAULT_SLICE: r_cfg.default_slice <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    etq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .i_clock_percent (r_cfg.clock_percent),
        .o_cmd_valid     (f_valid),
        .i_cmd_ready     (q_ready),
        .o_cmd           (f_cmd)
    );

    etq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    etq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KIND_BITS   (KIND_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

>>> rtl/etq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etq_checker
// Port-level checks of the event timing queue, bound to the top level.
// ----------------------------------------------------------------------------
module etq_checker import etq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> o_out_data.last && !o_out_data.fired)
        else $error("error status on a multi-beat or fired result");

    a_unfired_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.fired |->
            (o_out_data.late_cycles == '0) && (o_out_data.fired_user == '0) && o_out_data.last)
        else $error("unfired result carries event data");
endmodule

bind event_timing_queue_unit etq_checker u_etq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
